### hw/rtl/acfp_pkg.sv
package acfp_pkg;

    localparam logic [6:0] CLASSIC_MAX_BYTES = 7'd8;
    localparam logic [6:0] FD_MAX_BYTES      = 7'd64;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_R_UP   = 8'h52;
    localparam logic [7:0] CH_R_LOW  = 8'h72;

    localparam logic [4:0] NIB_NONHEX = 5'd16;
    localparam logic [4:0] NIB_DLC_MAX = 5'd8;

    localparam logic [31:0] FLAG_EFF = 32'h8000_0000;
    localparam logic [31:0] FLAG_RTR = 32'h4000_0000;

    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_CLASSIC = 2'd1;
    localparam logic [1:0] ST_FD      = 2'd2;

    typedef enum logic [6:0] {
        PH_ID       = 7'b0000001,
        PH_AFTER    = 7'b0000010,
        PH_RTR      = 7'b0000100,
        PH_FDFLAG   = 7'b0001000,
        PH_DATA     = 7'b0010000,
        PH_DATA_DOT = 7'b0100000,
        PH_DONE     = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  byte_value;
        logic [5:0]  byte_index;
        logic [31:0] frame_id;
        logic [6:0]  data_length;
        logic [3:0]  fd_flags;
        logic [1:0]  frame_status;
        logic        last_result;
    } t_out_item;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = NIB_NONHEX;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

### hw/rtl/ascii_can_frame_parser_core.sv
// Text CAN frame decoder ("id#data", "id#R", "id##<flags>data").
// Input channel: i_valid / o_stall / i_data, one ASCII character per
// transaction, end_of_text set on the last character of a string.
// Output channel: o_valid / i_stall / o_data, one result per transaction:
// a data byte (item_kind 0) as soon as its second nibble arrives, and a
// frame summary (item_kind 1, last_result 1) after the last character.
// Each result is written into the output queue when its character is accepted.
// Throughput: one character per cycle while o_stall is low; the decode is
// a single registered step per character. A character that completes a byte
// and ends the string yields two results, which leave the four-entry output
// queue one per cycle while i_stall is low.
// o_stall rises when the output queue has fewer than two free entries, so
// a stalled receiver holds the input side back once three or four results wait.
// Reset (i_rst_n low, synchronous) empties the queue and returns the
// decoder to the start of a string; each summary does the same for the
// decoder.
module ascii_can_frame_parser_core
    import acfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_pos,      n_pos;
    logic [31:0] r_acc,      n_acc;
    logic [7:0]  r_marks,    n_marks;
    logic [31:0] r_id,       n_id;
    logic [3:0]  r_flags,    n_flags;
    logic        r_fd,       n_fd;
    logic [6:0]  r_bytes,    n_bytes;
    logic [3:0]  r_upper,    n_upper;
    logic        r_half,     n_half;
    logic [3:0]  r_rlen,     n_rlen;
    logic        r_failed,   n_failed;

    t_out_item          r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [OQ_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [OQ_AW:0]     r_count,  n_count;

    logic       in_acc;
    logic       out_acc;
    logic [4:0] nb;
    logic       push_byte;
    logic       push_sum;
    t_out_item  byte_res;
    t_out_item  sum_res;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign nb      = hex_value(i_data.text_char);
    assign o_valid = (r_count != '0);
    assign o_stall = (r_count > (OQ_AW+1)'(OQ_DEPTH - 2));
    assign o_data  = r_oq[r_rd_ptr];

    always_comb begin
        logic       do_data;
        logic [6:0] limit;
        logic       valid_frame;
        logic       remote;

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_marks  = r_marks;
        n_id     = r_id;
        n_flags  = r_flags;
        n_fd     = r_fd;
        n_bytes  = r_bytes;
        n_upper  = r_upper;
        n_half   = r_half;
        n_rlen   = r_rlen;
        n_failed = r_failed;
        do_data  = 1'b0;
        limit    = CLASSIC_MAX_BYTES;
        push_byte = 1'b0;
        push_sum  = 1'b0;
        byte_res = '0;
        sum_res  = '0;
        valid_frame = 1'b0;
        remote = 1'b0;

        if (in_acc) begin
            if (!r_failed) begin
                case (r_phase)
                    PH_ID: begin
                        if (r_pos == 4'd3 && i_data.text_char == CH_HASH) begin
                            if (r_marks[2:0] != 3'b000) begin
                                n_failed = 1'b1;
                            end else begin
                                n_id    = {20'h0, r_acc[11:0]};
                                n_phase = PH_AFTER;
                            end
                        end else if (r_pos >= 4'd8) begin
                            if (i_data.text_char == CH_HASH && r_marks == 8'h00) begin
                                n_id    = r_acc[29] ? r_acc : (r_acc | FLAG_EFF);
                                n_phase = PH_AFTER;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end else begin
                            if (nb == NIB_NONHEX) begin
                                n_marks[r_pos[2:0]] = 1'b1;
                            end
                            n_acc = {r_acc[27:0], nb[3:0]};
                            n_pos = r_pos + 4'd1;
                        end
                    end
                    PH_AFTER: begin
                        if (i_data.text_char == CH_R_UP || i_data.text_char == CH_R_LOW) begin
                            n_id    = r_id | FLAG_RTR;
                            n_phase = PH_RTR;
                        end else if (i_data.text_char == CH_HASH) begin
                            n_fd    = 1'b1;
                            n_phase = PH_FDFLAG;
                        end else begin
                            n_phase = PH_DATA;
                            do_data = 1'b1;
                        end
                    end
                    PH_RTR: begin
                        if (nb <= NIB_DLC_MAX) begin
                            n_rlen = nb[3:0];
                        end
                        n_phase = PH_DONE;
                    end
                    PH_FDFLAG: begin
                        if (nb == NIB_NONHEX) begin
                            n_failed = 1'b1;
                        end else begin
                            n_flags = nb[3:0];
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA, PH_DATA_DOT: begin
                        do_data = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            limit = r_fd ? FD_MAX_BYTES : CLASSIC_MAX_BYTES;
            if (do_data && r_bytes < limit) begin
                if (r_half) begin
                    if (nb == NIB_NONHEX) begin
                        n_failed = 1'b1;
                    end else begin
                        push_byte           = 1'b1;
                        byte_res.item_kind  = KIND_BYTE;
                        byte_res.byte_value = {r_upper, nb[3:0]};
                        byte_res.byte_index = r_bytes[5:0];
                        n_bytes = r_bytes + 7'd1;
                        n_half  = 1'b0;
                        n_phase = PH_DATA;
                    end
                end else if (i_data.text_char == CH_DOT && n_phase == PH_DATA) begin
                    n_phase = PH_DATA_DOT;
                end else if (nb == NIB_NONHEX) begin
                    n_failed = 1'b1;
                end else begin
                    n_upper = nb[3:0];
                    n_half  = 1'b1;
                    n_phase = PH_DATA;
                end
            end

            if (i_data.end_of_text) begin
                valid_frame = !n_failed && n_phase != PH_ID && n_phase != PH_FDFLAG && !n_half;
                remote      = (n_phase == PH_RTR) || (n_phase == PH_DONE);
                push_sum             = 1'b1;
                sum_res.item_kind    = KIND_SUMMARY;
                sum_res.last_result  = 1'b1;
                if (valid_frame) begin
                    sum_res.frame_id     = n_id;
                    sum_res.data_length  = remote ? {3'b000, n_rlen} : n_bytes;
                    sum_res.fd_flags     = n_fd ? n_flags : 4'h0;
                    sum_res.frame_status = n_fd ? ST_FD : ST_CLASSIC;
                end else begin
                    sum_res.frame_status = ST_INVALID;
                end
                n_phase  = PH_ID;
                n_pos    = '0;
                n_acc    = '0;
                n_marks  = '0;
                n_id     = '0;
                n_flags  = '0;
                n_fd     = 1'b0;
                n_bytes  = '0;
                n_upper  = '0;
                n_half   = 1'b0;
                n_rlen   = '0;
                n_failed = 1'b0;
            end
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr + OQ_AW'(push_byte) + OQ_AW'(push_sum);
        n_rd_ptr = r_rd_ptr + OQ_AW'(out_acc);
        n_count  = r_count + (OQ_AW+1)'(push_byte) + (OQ_AW+1)'(push_sum)
                   - (OQ_AW+1)'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID;
            r_pos    <= '0;
            r_acc    <= '0;
            r_marks  <= '0;
            r_id     <= '0;
            r_flags  <= '0;
            r_fd     <= 1'b0;
            r_bytes  <= '0;
            r_upper  <= '0;
            r_half   <= 1'b0;
            r_rlen   <= '0;
            r_failed <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_marks  <= n_marks;
            r_id     <= n_id;
            r_flags  <= n_flags;
            r_fd     <= n_fd;
            r_bytes  <= n_bytes;
            r_upper  <= n_upper;
            r_half   <= n_half;
            r_rlen   <= n_rlen;
            r_failed <= n_failed;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_byte) begin
            r_oq[r_wr_ptr] <= byte_res;
            if (push_sum) begin
                r_oq[r_wr_ptr + OQ_AW'(1)] <= sum_res;
            end
        end else if (push_sum) begin
            r_oq[r_wr_ptr] <= sum_res;
        end
    end

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("output queue overflow");

    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.end_of_text) |=> o_valid)
        else $error("no result after end of text");

    a_eot_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.end_of_text) |=> (r_phase == PH_ID && r_pos == '0 && !r_failed))
        else $error("decoder not restarted after end of text");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.item_kind == o_data.last_result))
        else $error("summary and last flag disagree");
`endif

endmodule
